>>> hdl/u2c_pkg.sv
package u2c_pkg;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } res_t;

  // results one input transaction hands to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  // 11-bit code point of a two-byte sequence to a cp437 character
  function automatic logic [7:0] map_symbol(input logic [10:0] cp);
    logic [7:0] ch;
    unique case (cp)
      11'h0E4: ch = 8'h84;
      11'h0C4: ch = 8'h8E;
      11'h0F6: ch = 8'h94;
      11'h0D6: ch = 8'h99;
      11'h0FC: ch = 8'h81;
      11'h0DC: ch = 8'h9A;
      11'h0DF: ch = 8'hE1;
      11'h0B0: ch = 8'hF8;
      default: ch = QMARK;
    endcase
    return ch;
  endfunction

endpackage

>>> hdl/u2c_decode.sv
module u2c_decode
  import u2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       string_last,
  output push_t      push
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_TWO     = 2'd1,
    MODE_THREE_A = 2'd2,
    MODE_THREE_B = 2'd3
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [4:0] lead_r, lead_nxt;

  logic       is_ascii, is_lead2, is_lead3;
  logic [7:0] idle_ch;
  logic [7:0] sym_ch;

  assign is_ascii = (in_byte & ASCII_MASK) == 8'h00;
  assign is_lead2 = (in_byte & LEAD2_MASK) == LEAD2_CODE;
  assign is_lead3 = (in_byte & LEAD3_MASK) == LEAD3_CODE;
  // a byte handled afresh either passes through or becomes '?'
  assign idle_ch  = is_ascii ? in_byte : QMARK;
  assign sym_ch   = map_symbol({lead_r, in_byte[5:0]});

  always_comb begin
    mode_nxt = mode_r;
    lead_nxt = lead_r;
    push     = '0;
    if (fire) begin
      unique case (mode_r)
        MODE_TWO: begin
          mode_nxt  = MODE_IDLE;
          push.cnt  = 2'd1;
          push.res0 = '{out_byte: sym_ch, run_last: 1'b1, string_end: string_last};
        end
        MODE_THREE_A: begin
          if (!string_last) begin
            mode_nxt = MODE_THREE_B;
          end else begin
            // sequence cut short: '?' for the lead, then this byte afresh
            mode_nxt  = MODE_IDLE;
            push.cnt  = 2'd2;
            push.res0 = '{out_byte: QMARK, run_last: 1'b0, string_end: 1'b0};
            push.res1 = '{out_byte: idle_ch, run_last: 1'b1, string_end: 1'b1};
          end
        end
        MODE_THREE_B: begin
          mode_nxt  = MODE_IDLE;
          push.cnt  = 2'd1;
          push.res0 = '{out_byte: QMARK, run_last: 1'b1, string_end: string_last};
        end
        default: begin
          if (!is_ascii && is_lead2 && !string_last) begin
            mode_nxt = MODE_TWO;
            lead_nxt = in_byte[4:0];
          end else if (!is_ascii && is_lead3 && !string_last) begin
            mode_nxt = MODE_THREE_A;
          end else begin
            push.cnt  = 2'd1;
            push.res0 = '{out_byte: idle_ch, run_last: 1'b1, string_end: string_last};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      lead_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      lead_r <= lead_nxt;
    end
  end

  a_idle_after_string_end: assert property (@(posedge clk) disable iff (!rst_n)
    fire && string_last |=> mode_r == MODE_IDLE)
    else $error("decoder not idle after final byte of string");

  a_two_results_only_cut_short: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> mode_r == MODE_THREE_A && string_last)
    else $error("two results outside a cut-short three-byte sequence");

endmodule

>>> hdl/u2c_out_fifo.sv
module u2c_out_fifo
  import u2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       room,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tuser,   // run_last
  output logic       out_tlast    // string_end
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  res_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;
  res_t            head;

  assign head       = mem_r[rd_ptr_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = head.out_byte;
  assign out_tuser  = head.run_last;
  assign out_tlast  = head.string_end;
  // space for the largest burst of one transaction
  assign room       = cnt_r <= CW'(DEPTH - 2);
  assign pop        = out_tvalid && out_tready;

  assign wr_ptr_nxt = wr_ptr_r + AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign cnt_nxt    = cnt_r + CW'(push.cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + AW'(1)] <= push.res1;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("results pushed without room in output queue");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("output queue count beyond depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.cnt == 2'd0 |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("output queue count wrong after pop");

endmodule

>>> hdl/utf8_to_cp437_transcoder_core.sv
// utf-8 to cp437 transcoder, one byte per transaction in, 0..2 characters out
// path: each input byte is registered in the input staging register, decoded and
//   written to the output queue, which drives the output
// throughput: one input byte per cycle while the output queue has room; a byte that
//   gives two results is absorbed by the 4-entry output queue
// reset: synchronous active-low rst_n empties the input stage and queue, decoder idle
module utf8_to_cp437_transcoder_core
  import u2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // in_byte
  input  logic       in_tlast,    // string_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tuser,   // run_last
  output logic       out_tlast    // string_end
);

  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       room;
  logic       fire;
  push_t      push;

  assign fire      = stg_valid_r && room;
  assign in_tready = !stg_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  u2c_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .in_byte     (stg_byte_r),
    .string_last (stg_last_r),
    .push        (push)
  );

  u2c_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/tb.sv
module tb;
  import u2c_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 400;
  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {
    DEC_IDLE,
    DEC_TWO,
    DEC_THREE_A,
    DEC_THREE_B
  } dec_mode_t;

  class cp437_scoreboard;
    dec_mode_t mode;
    logic [4:0] lead_low;
    res_t expected_chars[$];
    int errors;

    function new();
      mode = DEC_IDLE;
      lead_low = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void push_char(logic [7:0] ch, logic run_end, logic str_end);
      res_t r;
      r.out_byte = ch;
      r.run_last = run_end;
      r.string_end = str_end;
      expected_chars.push_back(r);
    endfunction

    function logic [7:0] cp437_of(logic [10:0] cp);
      case (cp)
        11'h0E4: return 8'h84;
        11'h0C4: return 8'h8E;
        11'h0F6: return 8'h94;
        11'h0D6: return 8'h99;
        11'h0FC: return 8'h81;
        11'h0DC: return 8'h9A;
        11'h0DF: return 8'hE1;
        11'h0B0: return 8'hF8;
        default: return QMARK;
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic last);
      case (mode)
        DEC_TWO: begin
          mode = DEC_IDLE;
          push_char(cp437_of({lead_low, b[5:0]}), 1'b1, last);
        end
        DEC_THREE_A: begin
          if (!last) begin
            mode = DEC_THREE_B;
          end else begin
            // cut short: lead gives '?', then this byte is decoded on its own
            mode = DEC_IDLE;
            push_char(QMARK, 1'b0, 1'b0);
            push_char(((b & ASCII_MASK) == 8'h00) ? b : QMARK, 1'b1, 1'b1);
          end
        end
        DEC_THREE_B: begin
          mode = DEC_IDLE;
          push_char(QMARK, 1'b1, last);
        end
        default: begin
          if ((b & ASCII_MASK) == 8'h00) begin
            push_char(b, 1'b1, last);
          end else if ((b & LEAD2_MASK) == LEAD2_CODE && !last) begin
            lead_low = b[4:0];
            mode = DEC_TWO;
          end else if ((b & LEAD3_MASK) == LEAD3_CODE && !last) begin
            mode = DEC_THREE_A;
          end else begin
            push_char(QMARK, 1'b1, last);
          end
        end
      endcase
    endfunction

    function void check_result(logic [7:0] ch, logic run_end, logic str_end);
      res_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char %h run_last %b string_end %b",
                 $time, ch, run_end, str_end);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, ch);
        errors++;
      end
      if (run_end !== want.run_last) begin
        $display("%0t: run_last expected %b actual %b", $time, want.run_last, run_end);
        errors++;
      end
      if (str_end !== want.string_end) begin
        $display("%0t: string_end expected %b actual %b",
                 $time, want.string_end, str_end);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int cycle_count = 0;

  cp437_scoreboard sb = new();

  utf8_to_cp437_transcoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: check each transaction, then pick next ready value
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tuser, out_tlast);
      end
      if (stall_req != stall_seen) begin
        stall_seen <= stall_req;
        stall_left <= STALL_CYCLES;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // utf-8 encodings of the eight mapped symbols
  function automatic logic [15:0] symbol_utf8(int idx);
    case (idx)
      0: return 16'hC3A4;
      1: return 16'hC384;
      2: return 16'hC3B6;
      3: return 16'hC396;
      4: return 16'hC3BC;
      5: return 16'hC39C;
      6: return 16'hC39F;
      default: return 16'hC2B0;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b, last);
  endtask

  // one string of random sequences, sometimes cut off mid-sequence
  task automatic send_random_string(output int n_sent);
    logic [7:0] text[$];
    logic [15:0] sym;
    int n_tok;
    int r;
    int cut;
    n_tok = $urandom_range(1, 8);
    for (int t = 0; t < n_tok; t++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        text.push_back(8'($urandom_range(8'h7F)));
      end else if (r < 55) begin
        sym = symbol_utf8($urandom_range(7));
        text.push_back(sym[15:8]);
        text.push_back(sym[7:0]);
      end else if (r < 65) begin
        text.push_back(8'hC0 | 8'($urandom_range(31)));
        text.push_back(8'($urandom_range(255)));
      end else if (r < 75) begin
        text.push_back(8'hE0 | 8'($urandom_range(15)));
        text.push_back(8'h80 | 8'($urandom_range(63)));
        text.push_back(8'h80 | 8'($urandom_range(63)));
      end else if (r < 85) begin
        text.push_back(8'($urandom_range(255)));
      end else if (r < 92) begin
        text.push_back(8'h80 | 8'($urandom_range(63)));
      end else begin
        text.push_back(8'hF0 | 8'($urandom_range(15)));
      end
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(1, text.size());
      while (text.size() > cut) void'(text.pop_back());
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    n_sent = text.size();
  endtask

  task automatic run_random(input int target);
    int done;
    int n;
    done = 0;
    while (done < target) begin
      send_random_string(n);
      done += n;
    end
  endtask

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 87;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ascii extremes, mapped symbols, unmapped and odd sequences
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA4, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hB0, 1'b1);
    // ascii byte and lead byte swallowed as continuation
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hC3, 1'b0);
    // leads on the final byte of a string
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b1);
    // full three-byte sequence
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b1);
    // three-byte sequence cut short by string end
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'hC3, 1'b1);
    // stray continuation, a four-byte lead and an invalid byte
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b1);

    run_random(PHASE_ITEMS);

    send_idle_pct = 87;
    recv_idle_pct = 16;
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long output stall while input keeps coming, fills the queue
    stall_req <= stall_req + 1;
    run_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/u2c_pkg.sv
hdl/u2c_decode.sv
hdl/u2c_out_fifo.sv
hdl/utf8_to_cp437_transcoder_core.sv
tb/tb.sv
